[hw/rtl/hbq_pkg.sv]
`timescale 1ns / 1ps

package hbq_pkg;

  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ENTRY_COUNT_W = 9;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RL,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP
  } fsm_e;

  typedef struct packed {
    logic signed [DATA_W-1:0]  removed_value;
    logic signed [DATA_W-1:0]  top_value;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic                      is_empty;
    status_e                   status;
  } res_t;

endpackage

[hw/rtl/hbq_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read.
module hbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/hbq_ctrl.sv]
`timescale 1ns / 1ps

// Heap sequencer: sift-up / sift-down over the entry RAM, one level at a time.
module hbq_ctrl #(
  parameter int unsigned CAPACITY = hbq_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [hbq_pkg::DATA_W-1:0] value_i,
  output logic                              mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]       mem_waddr_o,
  output logic [hbq_pkg::DATA_W-1:0]        mem_wdata_o,
  output logic                              mem_re_o,
  output logic [$clog2(CAPACITY)-1:0]       mem_raddr_o,
  input  logic [hbq_pkg::DATA_W-1:0]        mem_rdata_i,
  output logic                              res_valid_o,
  input  logic                              res_stall_i,
  output hbq_pkg::res_t                     res_o
);

  import hbq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = AW + 2;
  localparam int unsigned EW = (CW > ENTRY_COUNT_W) ? CW : ENTRY_COUNT_W;

  fsm_e                     state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] lv_q, lv_d;
  logic                     has_right_q, has_right_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;
  logic signed [DATA_W-1:0] top_q, top_d;
  status_e                  status_q, status_d;
  logic                     resp_q, resp_d;

  logic signed [DATA_W-1:0] rd;
  logic [AW-1:0]            pos_m1;
  logic [AW-1:0]            parent;
  logic [KW-1:0]            kid_l;
  logic [KW-1:0]            kid_r;
  logic [KW-1:0]            n_ext;
  logic                     in_acc;
  logic [EW-1:0]            cnt_ext;

  assign rd     = $signed(mem_rdata_i);
  assign pos_m1 = pos_q - 1'b1;
  assign parent = AW'(pos_m1 >> 1);
  assign kid_l  = KW'({pos_q, 1'b1});
  assign kid_r  = kid_l + 1'b1;
  assign n_ext  = KW'(count_q);

  // resp_q marks a finished transaction waiting for the result slot
  assign in_stall_o = (state_q != S_IDLE) || resp_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    lv_d        = lv_q;
    has_right_d = has_right_q;
    removed_d   = removed_q;
    status_d    = status_q;
    resp_d      = resp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (resp_q && !res_stall_i) begin
          resp_d = 1'b0;
        end
        if (in_acc) begin
          status_d  = ST_OK;
          removed_d = '0;
          if (req_type_i == REQ_PUSH) begin
            if (count_q >= CW'(CAPACITY)) begin
              status_d = ST_FULL;
              resp_d   = 1'b1;
            end else begin
              val_d   = value_i;
              pos_d   = AW'(count_q);
              count_d = count_q + 1'b1;
              state_d = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              resp_d   = 1'b1;
            end else begin
              removed_d = top_q;
              count_d   = count_q - 1'b1;
              if (count_q == CW'(1)) begin
                resp_d = 1'b1;
              end else begin
                state_d = S_DN_RL;
              end
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          resp_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = parent;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we_o = 1'b1;
        if (val_q < rd) begin
          mem_wdata_o = rd;
          pos_d       = parent;
          state_d     = S_UP_RD;
        end else begin
          resp_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_RL: begin
        // count_q already holds the new count: it addresses the old last entry
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(count_q);
        state_d     = S_DN_LAST;
      end
      S_DN_LAST: begin
        val_d   = rd;
        pos_d   = '0;
        state_d = S_DN_L;
      end
      S_DN_L: begin
        if (kid_l >= n_ext) begin
          mem_we_o = 1'b1;
          resp_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = kid_l[AW-1:0];
          state_d     = S_DN_R;
        end
      end
      S_DN_R: begin
        lv_d = rd;
        if (kid_r < n_ext) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = kid_r[AW-1:0];
          has_right_d = 1'b1;
        end else begin
          has_right_d = 1'b0;
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we_o = 1'b1;
        // left child wins a tie
        if (has_right_q && (rd < lv_q)) begin
          if (rd < val_q) begin
            mem_wdata_o = rd;
            pos_d       = kid_r[AW-1:0];
            state_d     = S_DN_L;
          end else begin
            resp_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          if (lv_q < val_q) begin
            mem_wdata_o = lv_q;
            pos_d       = kid_l[AW-1:0];
            state_d     = S_DN_L;
          end else begin
            resp_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // root mirror: every write to slot zero updates it
  always_comb begin
    top_d = top_q;
    if (mem_we_o && (mem_waddr_o == '0)) begin
      top_d = $signed(mem_wdata_o);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      resp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      resp_q  <= resp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    val_q       <= val_d;
    lv_q        <= lv_d;
    has_right_q <= has_right_d;
    removed_q   <= removed_d;
    top_q       <= top_d;
    status_q    <= status_d;
  end

  assign cnt_ext     = EW'(count_q);
  assign res_valid_o = resp_q && (state_q == S_IDLE);

  always_comb begin
    res_o.removed_value = removed_q;
    res_o.top_value     = (count_q == '0) ? '0 : top_q;
    res_o.entry_count   = cnt_ext[ENTRY_COUNT_W-1:0];
    res_o.is_empty      = (count_q == '0);
    res_o.status        = status_q;
  end

endmodule

[hw/rtl/binary_min_heap_queue_top.sv]
`timescale 1ns / 1ps
// Transactions: one at a time; the input stalls from acceptance until the result has moved
//   into the output register. A push climbs one level per step (parent read, then compare
//   and write); a pop reads the old last entry, then per level reads both children and compares.
// Reset (rst_ni, async, active low) empties the queue; RAM contents are left as they are.
module binary_min_heap_queue_top #(
  parameter int unsigned CAPACITY = hbq_pkg::CAPACITY_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     req_type_i,
  input  logic signed [hbq_pkg::DATA_W-1:0]        value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [hbq_pkg::DATA_W-1:0]        removed_value_o,
  output logic signed [hbq_pkg::DATA_W-1:0]        top_value_o,
  output logic [hbq_pkg::ENTRY_COUNT_W-1:0]        entry_count_o,
  output logic                                     is_empty_o,
  output logic [1:0]                               status_o
);

  import hbq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  // Entry RAM port signals
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Sequencer result and output register
  logic res_valid;
  logic res_stall;
  res_t res;
  res_t out_q;
  logic out_valid_q;

  hbq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hbq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res)
  );

  // Output register: the sequencer hands over a result only when the slot
  // is free or is being emptied in the same cycle.
  assign res_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = out_q.removed_value;
  assign top_value_o     = out_q.top_value;
  assign entry_count_o   = out_q.entry_count;
  assign is_empty_o      = out_q.is_empty;
  assign status_o        = out_q.status;

endmodule

[hw/rtl/hbq_checker.sv]
`timescale 1ns / 1ps

module hbq_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_valid_i,
  input logic                                     in_stall_o,
  input logic                                     out_valid_o,
  input logic                                     out_stall_i,
  input logic signed [hbq_pkg::DATA_W-1:0]        removed_value_o,
  input logic signed [hbq_pkg::DATA_W-1:0]        top_value_o,
  input logic [hbq_pkg::ENTRY_COUNT_W-1:0]        entry_count_o,
  input logic                                     is_empty_o,
  input logic [1:0]                               status_o
);

  import hbq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(top_value_o)
      && $stable(status_o))
    else $error("result dropped or changed while stalled");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (entry_count_o == '0) && (top_value_o == '0))
    else $error("empty queue reports entries or a minimum");

  a_fail_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> removed_value_o == '0)
    else $error("refused transaction reports a removed value");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> is_empty_o)
    else $error("pop on empty with a non-empty queue");

  // one transaction at a time: input stalls right after an accept
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while one is in flight");

endmodule

bind binary_min_heap_queue_top hbq_checker u_hbq_checker (.*);

[dv/heap_queue_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the heap queue, keeps a shadow heap and checks
// every result against it in order.
module heap_queue_checker #(
  parameter int unsigned CAPACITY = hbq_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                req_type_i,
  input  logic signed [hbq_pkg::DATA_W-1:0]   value_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [hbq_pkg::DATA_W-1:0]   removed_value_i,
  input  logic signed [hbq_pkg::DATA_W-1:0]   top_value_i,
  input  logic [hbq_pkg::ENTRY_COUNT_W-1:0]   entry_count_i,
  input  logic                                is_empty_i,
  input  logic [1:0]                          status_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  import hbq_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  logic signed [DATA_W-1:0] shadow_heap [CAPACITY];
  int unsigned              shadow_size;
  res_t                     queued_results [$];

  // Applies one request to the shadow heap and returns the result it should give.
  function automatic res_t apply_request(input logic req, input logic signed [DATA_W-1:0] val);
    res_t                     r;
    int unsigned              pos;
    int unsigned              up;
    int unsigned              kid;
    logic                     moving;
    logic signed [DATA_W-1:0] tmp;
    r.removed_value = '0;
    r.status        = ST_OK;
    if (req == REQ_PUSH) begin
      if (shadow_size >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_size;
        shadow_heap[pos] = val;
        shadow_size++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_heap[pos] < shadow_heap[up]) begin
            tmp              = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[up];
            shadow_heap[up]  = tmp;
            pos              = up;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else if (shadow_size == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed_value = shadow_heap[0];
      shadow_size--;
      shadow_heap[0] = shadow_heap[shadow_size];
      pos    = 0;
      moving = 1'b1;
      while (moving) begin
        kid = 2 * pos + 1;
        if (kid >= shadow_size) begin
          moving = 1'b0;
        end else begin
          // tie goes to the left child
          if (kid + 1 < shadow_size && shadow_heap[kid + 1] < shadow_heap[kid]) kid++;
          if (shadow_heap[kid] < shadow_heap[pos]) begin
            tmp              = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[kid];
            shadow_heap[kid] = tmp;
            pos              = kid;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end
    r.top_value   = (shadow_size != 0) ? shadow_heap[0] : '0;
    r.entry_count = ENTRY_COUNT_W'(shadow_size);
    r.is_empty    = (shadow_size == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t seen;
    res_t want;
    if (!rst_ni) begin
      shadow_size = 0;
      queued_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen.removed_value = removed_value_i;
        seen.top_value     = top_value_i;
        seen.entry_count   = entry_count_i;
        seen.is_empty      = is_empty_i;
        seen.status        = status_e'(status_i);
        if (queued_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: unexpected result: removed %0d top %0d count %0d empty %0b status %0d",
                     $time, seen.removed_value, seen.top_value, seen.entry_count,
                     seen.is_empty, seen.status);
        end else begin
          want = queued_results.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $time);
              $display("  expected: removed %0d top %0d count %0d empty %0b status %0d",
                       want.removed_value, want.top_value, want.entry_count,
                       want.is_empty, want.status);
              $display("  actual:   removed %0d top %0d count %0d empty %0b status %0d",
                       seen.removed_value, seen.top_value, seen.entry_count,
                       seen.is_empty, seen.status);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        queued_results.push_back(apply_request(req_type_i, value_i));
    end
    pending_o = queued_results.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the heap queue. All checking lives in the checker;
// this module only drives requests, stalls the result side and decides
// pass/fail from the checker's counters.
module tb_top;

  import hbq_pkg::*;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam int unsigned TARGET_ITEMS = 1650;
  // Slowest transaction is a pop; add the longest sender gap and the longest
  // result stall and take it many times over.
  localparam int unsigned IDLE_LIMIT   = 2000;
  // Drain time after the last expected result: a bit over one slow pop.
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      req_type_i;
  logic signed [DATA_W-1:0]  value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [DATA_W-1:0]  removed_value_o;
  logic signed [DATA_W-1:0]  top_value_o;
  logic [ENTRY_COUNT_W-1:0]  entry_count_o;
  logic                      is_empty_o;
  logic [1:0]                status_o;

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus-side occupancy and coverage tallies
  int unsigned fill_level;
  int unsigned sent;
  int unsigned push_cnt;
  int unsigned pop_cnt;
  int unsigned refused_cnt;
  int unsigned empty_pop_cnt;
  int unsigned full_hits;
  logic        calm;   // when set the sender never idles

  binary_min_heap_queue_top #(
    .CAPACITY (CAP)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_o (removed_value_o),
    .top_value_o     (top_value_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .status_o        (status_o)
  );

  heap_queue_checker #(
    .CAPACITY (CAP)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_i (removed_value_o),
    .top_value_i     (top_value_o),
    .entry_count_i   (entry_count_o),
    .is_empty_i      (is_empty_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Idle length: mostly zero or a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Value mix: full-range noise, a narrow band for lots of duplicates (ties
  // between siblings), the signed extremes, and small non-negative values.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    int unsigned              r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom;
    end else if (r < 70) begin
      v = DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
    end else if (r < 82) begin
      case ($urandom_range(0, 3))
        0:       v = {1'b1, {(DATA_W-1){1'b0}}};
        1:       v = {1'b0, {(DATA_W-1){1'b1}}};
        2:       v = '0;
        default: v = '1;
      endcase
    end else begin
      v = DATA_W'($urandom_range(0, 1000));
    end
    return v;
  endfunction

  // One transaction on the request side. Returns at the edge that accepted it.
  // Stall is looked at on the falling edge, where everything has settled.
  task automatic issue_request(input logic req, input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    logic        taken;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    sent++;
    if (req == REQ_PUSH) begin
      push_cnt++;
      if (fill_level >= CAP) begin
        refused_cnt++;
      end else begin
        fill_level++;
        if (fill_level == CAP) full_hits++;
      end
    end else begin
      pop_cnt++;
      if (fill_level == 0) empty_pop_cnt++;
      else fill_level--;
    end
  endtask

  // Hold the request side until every outstanding result has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic mixed_burst(input int unsigned n, input int unsigned pop_pct);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < pop_pct) issue_request(REQ_POP, pick_value());
      else issue_request(REQ_PUSH, pick_value());
    end
  endtask

  // Push until full, then a few more that must be refused.
  task automatic fill_up();
    while (fill_level < CAP) issue_request(REQ_PUSH, pick_value());
    repeat ($urandom_range(1, 3)) issue_request(REQ_PUSH, pick_value());
  endtask

  // Pop until empty, then one or two on the empty queue.
  task automatic drain_out();
    while (fill_level > 0) issue_request(REQ_POP, pick_value());
    repeat ($urandom_range(1, 2)) issue_request(REQ_POP, pick_value());
  endtask

  // Result-side back-pressure: stall-free runs (some long) broken by stalls
  // drawn from the same gap profile as the sender.
  initial begin : result_backpressure
    int unsigned run_len;
    int unsigned hold_len;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                             : $urandom_range(1, 8);
      hold_len = pick_gap();
      repeat (run_len) @(posedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Ends the run if no transaction moves on either side for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic signed [DATA_W-1:0] edge_vals [10];
    int unsigned              budget;
    int unsigned              burst_len;
    edge_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
                  32'sh0000_0001, 32'shAAAA_AAAA, 32'sh5555_5555,
                  32'sh0000_0005, 32'sh0000_0005, 32'sh0000_0005};
    fill_level    = 0;
    sent          = 0;
    push_cnt      = 0;
    pop_cnt       = 0;
    refused_cnt   = 0;
    empty_pop_cnt = 0;
    full_hits     = 0;
    calm          = 1'b0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    req_type_i    <= REQ_PUSH;
    value_i       <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pop on empty, signed extremes, alternating bit patterns,
    // equal values so siblings tie, then pop everything back out in order
    // and pop once more on the empty queue.
    issue_request(REQ_POP, '0);
    foreach (edge_vals[k]) issue_request(REQ_PUSH, edge_vals[k]);
    repeat (10) issue_request(REQ_POP, '1);
    issue_request(REQ_POP, '0);

    // Let the queue go fully quiet before random traffic starts.
    wait_all_results();

    // Growing traffic, then a full fill with refused pushes, churn at the
    // top, and a complete drain.
    mixed_burst(200, 40);
    fill_up();
    mixed_burst(150, 50);
    drain_out();
    wait_all_results();

    // Random phases until the item budget is spent; some run without gaps.
    // Fill and drain phases only start when they fit in what is left.
    while (sent < TARGET_ITEMS) begin
      calm   = ($urandom_range(0, 3) == 0);
      budget = TARGET_ITEMS - sent;
      case ($urandom_range(0, 9))
        0: begin
          if (CAP - fill_level + 3 <= budget) fill_up();
          else mixed_burst(budget, 50);
        end
        1: begin
          if (fill_level + 2 <= budget) drain_out();
          else mixed_burst(budget, 50);
        end
        default: begin
          burst_len = $urandom_range(50, 200);
          mixed_burst((burst_len < budget) ? burst_len : budget, $urandom_range(30, 65));
        end
      endcase
    end
    calm = 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d pushes (%0d refused at capacity), %0d pops (%0d on empty).",
             sent, push_cnt, refused_cnt, pop_cnt, empty_pop_cnt);
    $display("Queue reached its capacity of %0d entries %0d times.", CAP, full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failed results, %0d results never arrived", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
